// ----- rtl/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int UTD_QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int POINT_W         = 21;
    localparam int REP_W           = 3;

    localparam logic [POINT_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [POINT_W-1:0] CARRIAGE_RETURN  = 21'h00000D;
    localparam logic [POINT_W-1:0] SURR_HIGH_BASE   = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_LOW_BASE    = 21'h00DC00;
    localparam logic [POINT_W-1:0] SUPPLEMENTARY    = 21'h010000;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDE_UNITS = 2'd0,
        CFG_STRIP_CR   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic wide_units;
        logic strip_cr;
    } cfg_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [POINT_W-1:0] code_unit;
        logic               run_end;
    } out_item_t;

    // Work handed from the front to the back: a run of replacement
    // characters, optionally followed by one decoded code point.
    typedef struct packed {
        logic [REP_W-1:0]   rep_count;
        logic               has_point;
        logic               split;
        logic [POINT_W-1:0] point;
    } desc_t;

endpackage

// ----- rtl/utd_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts one byte per cycle while the queue is not full, tracks the open
// sequence and turns each byte into a descriptor of the results it causes.
// ----------------------------------------------------------------------------
module utd_front
    import utd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     queue_full,
    output logic     push,
    output desc_t    push_desc
);

    logic [POINT_W-1:0] partial_reg, partial_next;
    logic [2:0]         exp_len_reg, exp_len_next;
    logic [1:0]         taken_reg, taken_next;

    logic               accept;
    logic               is_cont;
    logic [1:0]         cont_taken;
    logic [POINT_W-1:0] cont_partial;
    logic [REP_W-1:0]   rep;
    logic               pv;
    logic [POINT_W-1:0] point;
    logic               keep_point;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign is_cont  = (in_data.byte_in[7:6] == 2'b10);

    assign cont_taken   = taken_reg + 2'd1;
    assign cont_partial = {partial_reg[POINT_W-7:0], in_data.byte_in[5:0]};

    always_comb
    begin
        partial_next = partial_reg;
        exp_len_next = exp_len_reg;
        taken_next   = taken_reg;
        rep          = '0;
        pv           = 1'b0;
        point        = '0;

        if ((exp_len_reg != 3'd0) && is_cont)
        begin
            if (({1'b0, cont_taken} + 3'd1) >= exp_len_reg)
            begin
                pv           = 1'b1;
                point        = cont_partial;
                partial_next = '0;
                exp_len_next = 3'd0;
                taken_next   = 2'd0;
            end
            else if (in_data.end_of_text)
            begin
                rep          = {1'b0, cont_taken} + 3'd1;
                partial_next = '0;
                exp_len_next = 3'd0;
                taken_next   = 2'd0;
            end
            else
            begin
                partial_next = cont_partial;
                taken_next   = cont_taken;
            end
        end
        else
        begin
            // A broken sequence first gives one replacement per byte taken.
            if (exp_len_reg != 3'd0)
            begin
                rep = {1'b0, taken_reg} + 3'd1;
            end
            partial_next = '0;
            exp_len_next = 3'd0;
            taken_next   = 2'd0;

            // The byte is then decoded as a lead.
            if (!in_data.byte_in[7])
            begin
                pv    = 1'b1;
                point = {13'd0, in_data.byte_in};
            end
            else if ((in_data.byte_in[7:5] == 3'b110) || (in_data.byte_in[7:4] == 4'b1110) ||
                     (in_data.byte_in[7:3] == 5'b11110))
            begin
                if (in_data.end_of_text)
                begin
                    rep = rep + 3'd1;
                end
                else if (in_data.byte_in[7:5] == 3'b110)
                begin
                    partial_next = {16'd0, in_data.byte_in[4:0]};
                    exp_len_next = 3'd2;
                end
                else if (in_data.byte_in[7:4] == 4'b1110)
                begin
                    partial_next = {17'd0, in_data.byte_in[3:0]};
                    exp_len_next = 3'd3;
                end
                else
                begin
                    partial_next = {18'd0, in_data.byte_in[2:0]};
                    exp_len_next = 3'd4;
                end
            end
            else
            begin
                rep = rep + 3'd1;
            end
        end
    end

    assign keep_point = pv && !(cfg.strip_cr && (point == CARRIAGE_RETURN));

    always_comb
    begin
        push_desc.rep_count = rep;
        push_desc.has_point = keep_point;
        push_desc.split     = keep_point && !cfg.wide_units && (point[POINT_W-1:16] != '0);
        push_desc.point     = point;
        push                = accept && ((rep != '0) || keep_point);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            exp_len_reg <= 3'd0;
            taken_reg   <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            exp_len_reg <= exp_len_next;
            taken_reg   <= taken_next;
        end
    end

endmodule

// ----- rtl/utd_fifo.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder descriptor queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module utd_fifo
    import utd_pkg::*;
#(
    parameter int DEPTH = UTD_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head_desc,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/utd_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Walks the head descriptor into the output register, one result per cycle while not stalled.
// ----------------------------------------------------------------------------
module utd_back
    import utd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  desc_t     head_desc,
    input  logic      empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg;
    logic [1:0]         idx_reg, idx_next;

    logic               load;
    logic               step;
    logic [REP_W-1:0]   total;
    logic               last;
    logic [POINT_W-1:0] offset;
    logic [POINT_W-1:0] high_unit;
    logic [POINT_W-1:0] low_unit;
    logic [POINT_W-1:0] unit;

    assign load  = !out_valid_reg || !out_stall;
    assign step  = load && !empty;
    assign total = head_desc.rep_count + {2'd0, head_desc.has_point} + {2'd0, head_desc.split};
    assign last  = (({1'b0, idx_reg} + 3'd1) == total);

    assign offset    = head_desc.point - SUPPLEMENTARY;
    assign high_unit = SURR_HIGH_BASE + {10'd0, offset[POINT_W-1:10]};
    assign low_unit  = SURR_LOW_BASE | {11'd0, head_desc.point[9:0]};

    always_comb
    begin
        if ({1'b0, idx_reg} < head_desc.rep_count)
        begin
            unit = REPLACEMENT_CHAR;
        end
        else if ({1'b0, idx_reg} == head_desc.rep_count)
        begin
            unit = head_desc.split ? high_unit : head_desc.point;
        end
        else
        begin
            unit = low_unit;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !empty;
        end
        if (step)
        begin
            pop      = last;
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.code_unit <= unit;
            out_data_reg.run_end   <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/utf8_to_utf16_decoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Streaming decoder from UTF-8 bytes to code points or UTF-16 code units.
// ----------------------------------------------------------------------------
// The decoder takes one UTF-8 byte per transfer and can accept a byte every
// cycle. Each byte gives zero to four results: a decoded code point (or a
// UTF-16 surrogate pair when wide_units is 0), and replacement characters
// U+FFFD for stray bytes, broken sequences and a sequence left open at the
// end of the text. The last result a byte causes carries run_end. The output
// drains one result per cycle while out_stall is low, which sets the
// sustained rate, and a queue of QUEUE_DEPTH descriptors between the
// decoding front end and the output sequencer absorbs bursts, so the input
// stalls only when that queue is full. The first result of a byte passes
// through the queue and then the output register before it appears on the
// output. Configuration writes are accepted every cycle and must only be
// issued while the decoder is idle.
module utf8_to_utf16_decoder
    import utd_pkg::*;
#(
    parameter int QUEUE_DEPTH = UTD_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input byte channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,

    // Result channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,

    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  push;
    desc_t push_desc;
    logic  pop;
    desc_t head_desc;
    logic  queue_full;
    logic  queue_empty;

    // The register file always takes a write; an index past the list is
    // simply ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDE_UNITS: cfg_next.wide_units = cfg_data;
                CFG_STRIP_CR:   cfg_next.strip_cr   = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wide_units <= 1'b1;
            cfg_reg.strip_cr   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end decodes each byte in the cycle of its transfer and
    // queues a descriptor when the byte causes any result.
    utd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    utd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // The back end expands a descriptor into replacement characters and
    // code units, one per cycle while out_stall is low, through its output register.
    utd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder testbench
// Feeds byte streams through the decoder and checks every result it returns.
// A short table of hand-picked bytes comes first. Random phases follow, one
// for each register setting, and mostly carry well-formed sequences with some
// broken ones mixed in. Results come from the table or a local predictor.
// ----------------------------------------------------------------------------
module testbench;

    import utd_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200000;
    // Idle cycles after the last expected result. They cover bytes that still
    // sit in the pipeline but produce nothing, such as lead bytes and dropped
    // carriage returns.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 86;
    localparam int MAX_REPORTS   = 40;
    // A unit count in the table that means "ask the predictor".
    localparam int PREDICTED     = -1;

    // Register indexes past the end of the list. The decoder must ignore them.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 2'd3;

    // UTF-8 byte tags and code point limits.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [POINT_W-1:0] BMP_LAST      = 21'h00FFFF;
    localparam logic [POINT_W-1:0] LOW_TEN_MASK  = 21'h0003FF;

    typedef struct packed {
        logic [7:0]         byte_val;
        logic               last_byte;
        int                 unit_count;
        logic [POINT_W-1:0] unit_val;
    } directed_row_t;

    // Hand-picked bytes, sent with the reset setting (whole code points, and
    // carriage returns dropped). Rows that carry a unit count list their
    // results directly: unit_count copies of unit_val. The other rows are
    // checked against the predictor.
    directed_row_t directed_rows [25] = '{
        '{8'h00, 1'b0, 1, 21'h000000},           // lowest ASCII
        '{8'h7F, 1'b0, 1, 21'h00007F},           // highest ASCII
        '{8'h80, 1'b0, 1, REPLACEMENT_CHAR},     // stray continuation
        '{8'hF8, 1'b0, 1, REPLACEMENT_CHAR},     // invalid lead, low end
        '{8'hFF, 1'b1, 1, REPLACEMENT_CHAR},     // invalid lead on the last byte
        '{8'h0D, 1'b0, 0, CARRIAGE_RETURN},      // carriage return is dropped
        '{8'hC3, 1'b0, PREDICTED, '0},           // two bytes: U+00E9
        '{8'hA9, 1'b0, PREDICTED, '0},
        '{8'hE2, 1'b0, PREDICTED, '0},           // three bytes: U+20AC
        '{8'h82, 1'b0, PREDICTED, '0},
        '{8'hAC, 1'b0, PREDICTED, '0},
        '{8'hF0, 1'b0, PREDICTED, '0},           // four bytes, ends the text
        '{8'h9F, 1'b0, PREDICTED, '0},
        '{8'h98, 1'b0, PREDICTED, '0},
        '{8'h80, 1'b1, PREDICTED, '0},
        '{8'hF7, 1'b0, PREDICTED, '0},           // largest value, above U+10FFFF
        '{8'hBF, 1'b0, PREDICTED, '0},
        '{8'hBF, 1'b0, PREDICTED, '0},
        '{8'hBF, 1'b0, PREDICTED, '0},
        '{8'hE2, 1'b0, PREDICTED, '0},           // broken by an ASCII byte
        '{8'h82, 1'b0, PREDICTED, '0},
        '{8'h41, 1'b0, PREDICTED, '0},
        '{8'hF0, 1'b0, PREDICTED, '0},           // text ends inside a sequence
        '{8'h9F, 1'b0, PREDICTED, '0},
        '{8'h98, 1'b1, 3, REPLACEMENT_CHAR}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic                   cfg_data  = 1'b0;

    // Predictor state: the current register setting and the open sequence.
    logic                   cfg_wide  = 1'b1;
    logic                   cfg_strip = 1'b1;
    logic [POINT_W-1:0]     gathered_bits = '0;
    logic [2:0]             open_length   = '0;
    logic [1:0]             cont_count    = '0;

    // Units that the byte being decoded produces, and every result still
    // owed by the decoder, oldest first.
    logic [POINT_W-1:0]     byte_units[$];
    out_item_t              pending_units[$];
    in_item_t               byte_stream[$];

    int                     mismatches   = 0;
    int                     cycle_count  = 0;
    int                     stall_left   = 0;
    bit                     idle_enable  = 1'b1;
    bit                     stall_enable = 1'b1;

    always #5 clk = ~clk;

    utf8_to_utf16_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void push_unit(input logic [POINT_W-1:0] unit);
        if (!(cfg_strip && unit == CARRIAGE_RETURN))
            byte_units.insert(byte_units.size(), unit);
    endfunction

    // A code point comes out whole in wide mode or when it fits in 16 bits.
    // Otherwise it is split into a surrogate pair, and that also happens to
    // values above U+10FFFF.
    function automatic void emit_point(input logic [POINT_W-1:0] point);
        logic [POINT_W-1:0] offset;
        if (cfg_wide || point <= BMP_LAST) begin
            push_unit(point);
        end
        else begin
            offset = point - SUPPLEMENTARY;
            push_unit(SURR_HIGH_BASE + (offset >> 10));
            push_unit(SURR_LOW_BASE + (point & LOW_TEN_MASK));
        end
    endfunction

    // One replacement for the lead and one for each continuation that was
    // already taken. The sequence is then closed.
    function automatic void abandon_sequence();
        for (int k = 0; k <= int'(cont_count); k++)
            emit_point(REPLACEMENT_CHAR);
        open_length   = '0;
        cont_count    = '0;
        gathered_bits = '0;
    endfunction

    function automatic void take_lead(input logic [7:0] c);
        if (c[7] == 1'b0) begin
            emit_point({13'd0, c});
        end
        else if (c[7:5] == LEAD2_TAG) begin
            gathered_bits = {16'd0, c[4:0]};
            open_length   = 3'd2;
            cont_count    = '0;
        end
        else if (c[7:4] == LEAD3_TAG) begin
            gathered_bits = {17'd0, c[3:0]};
            open_length   = 3'd3;
            cont_count    = '0;
        end
        else if (c[7:3] == LEAD4_TAG) begin
            gathered_bits = {18'd0, c[2:0]};
            open_length   = 3'd4;
            cont_count    = '0;
        end
        else begin
            emit_point(REPLACEMENT_CHAR);
        end
    endfunction

    // Works out the units that one accepted byte produces and leaves them in
    // byte_units.
    function automatic void decode_byte(input in_item_t item);
        logic [7:0] c;
        c = item.byte_in;
        byte_units.delete();
        if (open_length != 3'd0) begin
            if (c[7:6] == CONT_TAG) begin
                gathered_bits = {gathered_bits[POINT_W-7:0], c[5:0]};
                cont_count    = cont_count + 2'd1;
                if (int'(cont_count) + 1 >= int'(open_length)) begin
                    emit_point(gathered_bits);
                    open_length   = '0;
                    cont_count    = '0;
                    gathered_bits = '0;
                end
            end
            else begin
                // A bad continuation closes the open sequence. The same byte
                // is then decoded again as a lead.
                abandon_sequence();
                take_lead(c);
            end
        end
        else begin
            take_lead(c);
        end
        if (item.end_of_text && open_length != 3'd0)
            abandon_sequence();
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [POINT_W-1:0] got,
                                   input logic [POINT_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s got %h, expected %h",
                     cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_units.size() == 0) begin
            report_mismatch("result with nothing expected", got.code_unit, '0);
        end
        else begin
            want = pending_units.pop_front();
            if (got.code_unit !== want.code_unit)
                report_mismatch("code_unit", got.code_unit, want.code_unit);
            if (got.run_end !== want.run_end)
                report_mismatch("run_end", {20'd0, got.run_end}, {20'd0, want.run_end});
        end
    endtask

    // The output is sampled at the falling edge. out_stall only changes at the
    // rising edge, so a result seen here with out_stall low is the one that
    // transfers at the next rising edge. Expectations are queued at the
    // transfer edge of the input byte. That is always earlier than the
    // falling edge at which the byte's first result can show up.
    always @(negedge clk)
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            check_result(out_data);

    // The receiver stalls in random bursts while
    // stall_enable is set.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_enable && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // The run is stopped outright if it hangs, for example when results
    // that are still expected never arrive.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Sends one byte and waits for its transfer. Then it queues the results
    // the byte should produce: either unit_count copies of unit_val, or the
    // predictor's units when unit_count is PREDICTED. The predictor runs in
    // both cases so that its state keeps up with the byte stream.
    task automatic send_item(input in_item_t item, input int unit_count,
                             input logic [POINT_W-1:0] unit_val);
        bit        taken;
        out_item_t want_item;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end while (!taken);
        decode_byte(item);
        if (unit_count != PREDICTED) begin
            byte_units.delete();
            repeat (unit_count) byte_units.insert(byte_units.size(), unit_val);
        end
        foreach (byte_units[k]) begin
            want_item.code_unit = byte_units[k];
            want_item.run_end   = (k == byte_units.size() - 1);
            pending_units.insert(pending_units.size(), want_item);
        end
    endtask

    // Ends a phase. It waits until every expected result has come back, then
    // gives bytes that produce nothing time to leave the pipeline. After
    // that the decoder is idle and its registers may be written.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(negedge clk);
            taken = (cfg_ready === 1'b1);
            @(posedge clk);
        end while (!taken);
        if (index == CFG_WIDE_UNITS)
            cfg_wide = value;
        else if (index == CFG_STRIP_CR)
            cfg_strip = value;
    endtask

    // Writes both registers. It also writes one index past the end of the
    // list, which the decoder must ignore.
    task automatic set_config(input logic wide, input logic strip,
                              input logic [CFG_INDEX_W-1:0] spare_index,
                              input logic spare_value);
        write_reg(CFG_WIDE_UNITS, wide);
        write_reg(spare_index, spare_value);
        write_reg(CFG_STRIP_CR, strip);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void push_byte(input logic [7:0] value, input logic last_byte);
        in_item_t item;
        item.byte_in     = value;
        item.end_of_text = last_byte;
        byte_stream.insert(byte_stream.size(), item);
    endfunction

    function automatic logic [7:0] random_lead(input int length);
        logic [7:0] lead;
        case (length)
            1:       lead = ($urandom_range(0, 6) == 0) ? CARRIAGE_RETURN[7:0]
                                                        : {1'b0, 7'($urandom)};
            2:       lead = {LEAD2_TAG, 5'($urandom)};
            3:       lead = {LEAD3_TAG, 4'($urandom)};
            default: lead = {LEAD4_TAG, 3'($urandom)};
        endcase
        return lead;
    endfunction

    // Appends one random chunk to byte_stream. Most chunks are well-formed
    // sequences with random content. The rest are sequences broken by a bad
    // byte, sequences cut off by the end of the text, stray bytes and plain
    // noise. Some bytes carry end_of_text at random.
    function automatic void add_random_chunk();
        int         kind;
        int         length;
        int         conts;
        logic [7:0] value;
        kind   = $urandom_range(0, 99);
        length = $urandom_range(1, 4);
        if (kind < 60) begin
            if (length == 2 && $urandom_range(0, 7) == 0) begin
                // An overlong carriage return, which is decoded, not rejected.
                push_byte({LEAD2_TAG, 5'd0}, 1'b0);
                push_byte({CONT_TAG, CARRIAGE_RETURN[5:0]}, $urandom_range(0, 15) == 0);
            end
            else begin
                push_byte(random_lead(length), length == 1 && $urandom_range(0, 15) == 0);
                for (int k = 1; k < length; k++)
                    push_byte({CONT_TAG, 6'($urandom)}, $urandom_range(0, 15) == 0);
            end
        end
        else if (kind < 85) begin
            length = $urandom_range(2, 4);
            conts  = $urandom_range(0, length - 2);
            push_byte(random_lead(length), 1'b0);
            for (int k = 0; k < conts; k++)
                push_byte({CONT_TAG, 6'($urandom)}, kind >= 75 && k == conts - 1);
            if (kind < 75) begin
                // The sequence is broken by a byte that is not a continuation.
                value = 8'($urandom);
                if (value[7:6] == CONT_TAG)
                    value[6] = 1'b1;
                push_byte(value, $urandom_range(0, 15) == 0);
            end
            else if (conts == 0) begin
                // The text ends right after the lead.
                byte_stream[byte_stream.size() - 1].end_of_text = 1'b1;
            end
        end
        else if (kind < 92) begin
            value = ($urandom_range(0, 1) == 0) ? {CONT_TAG, 6'($urandom)}
                                                : {LEAD4_TAG, 3'($urandom)} | 8'h08;
            push_byte(value, $urandom_range(0, 15) == 0);
        end
        else begin
            push_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end
    endfunction

    task automatic run_random(input int count);
        byte_stream.delete();
        while (byte_stream.size() < count)
            add_random_chunk();
        foreach (byte_stream[i])
            send_item(byte_stream[i], PREDICTED, '0);
        finish_phase();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The table runs with the reset setting.
        foreach (directed_rows[r])
            send_item('{byte_in:     directed_rows[r].byte_val,
                        end_of_text: directed_rows[r].last_byte},
                      directed_rows[r].unit_count, directed_rows[r].unit_val);
        finish_phase();

        // UTF-16 units with carriage returns kept, then with them dropped.
        set_config(1'b0, 1'b0, CFG_SPARE_LOW, 1'b1);
        run_random(PHASE_ITEMS);
        set_config(1'b0, 1'b1, CFG_SPARE_HIGH, 1'b0);
        run_random(PHASE_ITEMS);

        // Whole code points with carriage returns kept.
        set_config(1'b1, 1'b0, CFG_SPARE_LOW, 1'b0);
        run_random(PHASE_ITEMS);

        // The last phase runs at full rate on both sides, with the reset
        // setting written back.
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
        set_config(1'b1, 1'b1, CFG_SPARE_HIGH, 1'b1);
        run_random(PHASE_ITEMS);

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
